FILE: sv/tty_line_discipline_core_defines.svh
// assertion macros shared by the line discipline rtl
`ifndef TTY_LINE_DISCIPLINE_CORE_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TLD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tld assertion failed");

// next-cycle implication, checked out of reset
`define TLD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tld assertion failed");

`endif

FILE: sv/tld_pkg.sv
// shared types and constants of the line discipline
package tld_pkg;

	localparam int LINE_DEPTH = 62;
	localparam int LEN_W      = 6;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int CHAR_W     = 8;
	localparam int CFG_W      = 6;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CHAR_W-1:0] DEL_CHAR  = 8'h7f;
	localparam logic [CHAR_W-1:0] LF_CHAR   = 8'h0a;
	localparam logic [CHAR_W-1:0] CR_CHAR   = 8'h0d;
	localparam logic [LEN_W-1:0]  LIMIT_MIN = 6'd2;
	localparam logic [LEN_W-1:0]  LIMIT_RST = 6'd62;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ECHO_ENABLE,
		REG_INPUT_CRLF,
		REG_OUTPUT_CRLF,
		REG_LINE_LIMIT
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEL_CR,
		SEL_CH,
		SEL_LINE
	} out_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_LF,
		ST_DECIDE,
		ST_ECHO_CR,
		ST_ECHO_CH,
		ST_LINE
	} state_t;

	typedef struct packed {
		logic     accept;
		logic     wr_lf;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_last;
		logic     rd_start;
		logic     rd_next;
		logic     len_clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rx_del;
		logic rx_crlf;
		logic len_zero;
		logic ch_lf;
		logic echo_en;
		logic out_crlf;
		logic deliver;
		logic line_end;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: sv/tld_ctrl.sv
// sequencing state machine of the line discipline
module tld_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tld_pkg::dp_stat_t   stat,
	output tld_pkg::ctrl_cmd_t  cmd
);
	import tld_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					// del on an empty line is dropped silently
					if (stat.rx_del && stat.len_zero) begin
						state_d = ST_IDLE;
					end else if (stat.rx_crlf) begin
						state_d = ST_WR_LF;
					end else begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_WR_LF: begin
				cmd.wr_lf = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.echo_en && stat.ch_lf && stat.out_crlf) begin
					state_d = ST_ECHO_CR;
				end else if (stat.echo_en) begin
					state_d = ST_ECHO_CH;
				end else if (stat.deliver) begin
					cmd.rd_start = 1'b1;
					state_d      = ST_LINE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ECHO_CR: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_CR;
					state_d      = ST_ECHO_CH;
				end
			end
			ST_ECHO_CH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_CH;
					cmd.out_last = !stat.deliver;
					if (stat.deliver) begin
						cmd.rd_start = 1'b1;
						state_d      = ST_LINE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_LINE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_LINE;
					cmd.out_last = stat.line_end;
					if (stat.line_end) begin
						cmd.len_clear = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/tld_dp.sv
// line store, length, settings and output register of the line discipline
module tld_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tld_pkg::CFG_W-1:0]     cfg_data,
	input  logic [tld_pkg::CHAR_W-1:0]    rx_char,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          kind,
	output logic [tld_pkg::CHAR_W-1:0]    out_char,
	output logic                          last,
	input  tld_pkg::ctrl_cmd_t            cmd,
	output tld_pkg::dp_stat_t             stat
);
	import tld_pkg::*;

	logic              echo_enable_q;
	logic              input_crlf_q;
	logic              output_crlf_q;
	logic [LEN_W-1:0]  line_limit_q;
	logic [LEN_W-1:0]  lim;

	logic [LEN_W-1:0]  len_q;
	logic [CHAR_W-1:0] ch_q;
	logic [ADDR_W-1:0] idx_q;
	logic [CHAR_W-1:0] rdata_q;
	logic [CHAR_W-1:0] mem_q [LINE_DEPTH];

	logic              out_valid_q;
	logic              kind_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic              rx_del;
	logic              rx_lf;
	logic              room;
	logic              rx_crlf;
	logic              has_space;
	logic              mem_we;
	logic [CHAR_W-1:0] wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_enable_q <= 1'b1;
			input_crlf_q  <= 1'b1;
			output_crlf_q <= 1'b1;
			line_limit_q  <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ECHO_ENABLE: echo_enable_q <= cfg_data[0];
				REG_INPUT_CRLF:  input_crlf_q  <= cfg_data[0];
				REG_OUTPUT_CRLF: output_crlf_q <= cfg_data[0];
				REG_LINE_LIMIT:  line_limit_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the limit into the usable range
	always_comb begin
		if (line_limit_q < LIMIT_MIN) begin
			lim = LIMIT_MIN;
		end else if (line_limit_q > LEN_W'(LINE_DEPTH)) begin
			lim = LEN_W'(LINE_DEPTH);
		end else begin
			lim = line_limit_q;
		end
	end

	// decode of the incoming character
	assign rx_del    = (rx_char == DEL_CHAR);
	assign rx_lf     = (rx_char == LF_CHAR);
	assign room      = (({1'b0, len_q} + (LEN_W+1)'(1)) < {1'b0, lim});
	assign rx_crlf   = rx_lf && input_crlf_q && room;
	assign has_space = (len_q < LEN_W'(LINE_DEPTH));

	// store write: first byte on accept, the lf of a cr lf pair afterwards
	assign mem_we  = ((cmd.accept && !rx_del) || cmd.wr_lf) && has_space;
	assign wr_data = cmd.wr_lf ? LF_CHAR : (rx_crlf ? CR_CHAR : rx_char);
	assign rd_en   = cmd.rd_start || cmd.rd_next;
	assign rd_addr = cmd.rd_start ? '0 : (idx_q + ADDR_W'(1));

	// line store, written and read through one port each, read registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[len_q[ADDR_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// held character of the current request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q <= rx_char;
		end
	end

	// line length and delivery index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.len_clear) begin
				len_q <= '0;
			end else if (cmd.accept && rx_del) begin
				if (len_q != '0) begin
					len_q <= len_q - LEN_W'(1);
				end
			end else if (mem_we) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (rd_en) begin
				idx_q <= rd_addr;
			end
		end
	end

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last_q <= cmd.out_last;
			case (cmd.out_sel)
				SEL_CR: begin
					kind_q <= 1'b0;
					char_q <= CR_CHAR;
				end
				SEL_CH: begin
					kind_q <= 1'b0;
					char_q <= ch_q;
				end
				default: begin
					kind_q <= 1'b1;
					char_q <= rdata_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_char  = char_q;
	assign last      = last_q;

	// status toward the controller
	always_comb begin
		stat          = '0;
		stat.rx_del   = rx_del;
		stat.rx_crlf  = rx_crlf;
		stat.len_zero = (len_q == '0);
		stat.ch_lf    = (ch_q == LF_CHAR);
		stat.echo_en  = echo_enable_q;
		stat.out_crlf = output_crlf_q;
		stat.deliver  = ((ch_q == LF_CHAR) || (ch_q == CR_CHAR) || (len_q >= lim))
			&& (len_q != '0);
		stat.line_end = ({1'b0, idx_q} == ((LEN_W+1)'(len_q) - (LEN_W+1)'(1)));
		stat.out_free = out_free;
	end

endmodule

FILE: sv/tty_line_discipline_core.sv
// steps: accept, an extra write state for a stored cr lf pair, a decision state, then
// one result per cycle while the output register has room; a request causes up to 64 results
// line bytes stream at one per cycle, unless the output stalls, from the
// single registered read port of the line store
// reset: settings return to defaults and the length to zero; the store is not cleared
// top level of the line discipline
`include "tty_line_discipline_core_defines.svh"

module tty_line_discipline_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tld_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tld_pkg::CHAR_W-1:0]    rx_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [tld_pkg::CHAR_W-1:0]    out_char,
	output logic                          last
);
	import tld_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	tld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tld_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_char   (rx_char),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.kind      (kind),
		.out_char  (out_char),
		.last      (last),
		.cmd       (cmd),
		.stat      (stat)
	);

	// a kept request blocks further input while it is worked on
	`TLD_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready && (rx_char != DEL_CHAR), !in_ready)
	// the last line byte empties the line
	`TLD_ASSERT_NEXT(a_line_clears, cmd.out_load && cmd.len_clear, stat.len_zero)
	// a result is only loaded into a free output register
	`TLD_ASSERT_IMPL(a_load_when_free, cmd.out_load, stat.out_free)

endmodule

FILE: tb/tty_line_discipline_core_tb.sv
// self-checking testbench of the tty line discipline core: directed edits, then random lines
`timescale 1ns / 100ps

module tty_line_discipline_core_tb;
	import tld_pkg::*;

	localparam logic KIND_ECHO     = 1'b0;
	localparam logic KIND_LINE     = 1'b1;
	localparam int   QUIET_LIMIT   = 3000;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   STREAM_ITEMS  = 40;
	localparam int   RANDOM_ITEMS  = 360;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] ch;
		logic              last;
	} tty_out_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [CHAR_W-1:0]    rx_char;
	logic                 out_valid;
	logic                 out_ready;
	logic                 kind;
	logic [CHAR_W-1:0]    out_char;
	logic                 last;

	// expected echo and line bytes, oldest first
	tty_out_t          line_exp[$];
	// shadow of the line being edited and of the settings
	logic [CHAR_W-1:0] line_buf [LINE_DEPTH];
	int                line_len;
	logic              echo_on;
	logic              crlf_in;
	logic              crlf_out;
	logic [LEN_W-1:0]  limit_reg;

	int errors     = 0;
	int quiet      = 0;
	int ready_hold = 0;
	int items_sent = 0;
	bit no_gaps    = 1'b0;

	tty_line_discipline_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_char   (rx_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.out_char  (out_char),
		.last      (last)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// append one byte to the line, dropped once the store is full
	task automatic store_char(input logic [CHAR_W-1:0] ch);
		if (line_len < LINE_DEPTH) begin
			line_buf[line_len] = ch;
			line_len++;
		end
	endtask

	// edit the shadow line with one received byte and queue the echo and line bytes
	task automatic edit_line(input logic [CHAR_W-1:0] ch);
		tty_out_t step_out[$];
		int       lim;
		lim = (limit_reg < LIMIT_MIN) ? int'(LIMIT_MIN) :
			(limit_reg > LINE_DEPTH) ? LINE_DEPTH : int'(limit_reg);
		if (ch == DEL_CHAR) begin
			// delete on an empty line is swallowed
			if (line_len == 0)
				return;
			line_len--;
		end else if (ch == LF_CHAR) begin
			if (crlf_in && line_len + 1 < lim)
				store_char(CR_CHAR);
			store_char(LF_CHAR);
		end else begin
			store_char(ch);
		end
		if (echo_on) begin
			if (ch == LF_CHAR && crlf_out)
				step_out.push_back('{KIND_ECHO, CR_CHAR, 1'b0});
			step_out.push_back('{KIND_ECHO, ch, 1'b0});
		end
		// hand out the line on a terminator or once it is full
		if (ch == LF_CHAR || ch == CR_CHAR || line_len >= lim) begin
			for (int i = 0; i < line_len; i++)
				step_out.push_back('{KIND_LINE, line_buf[i], 1'b0});
			line_len = 0;
		end
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i])
			line_exp.push_back(step_out[i]);
	endtask

	// idle cycles ahead of a request: mostly none or short, a few long
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 40)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// send one byte; valid stays up when another byte follows at once
	task automatic send_char(input logic [CHAR_W-1:0] ch, input bit more);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_char  <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		edit_line(ch);
		items_sent++;
		// drop valid and wait for the clock so the next request starts in a fresh step
		if (!more) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_chars(input logic [CHAR_W-1:0] seq[$]);
		foreach (seq[i])
			send_char(seq[i], i < seq.size() - 1);
	endtask

	// hold off until every expected byte is out and the pipeline is empty
	task automatic settle();
		while (line_exp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_ECHO_ENABLE: echo_on   = val[0];
			REG_INPUT_CRLF:  crlf_in   = val[0];
			REG_OUTPUT_CRLF: crlf_out  = val[0];
			REG_LINE_LIMIT:  limit_reg = val[LEN_W-1:0];
			default: ;
		endcase
	endtask

	// write all four settings once the core is idle; unused upper bits carry noise
	task automatic write_settings(input logic echo, input logic icrlf, input logic ocrlf,
			input logic [LEN_W-1:0] lim);
		settle();
		write_reg(REG_ECHO_ENABLE, (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(echo));
		write_reg(REG_INPUT_CRLF, (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(icrlf));
		write_reg(REG_OUTPUT_CRLF, (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(ocrlf));
		write_reg(REG_LINE_LIMIT, CFG_W'(lim));
		cfg_we <= 1'b0;
	endtask

	// default settings: delete on empty line, byte extremes, lf and cr endings
	task automatic test_default_line();
		send_chars({DEL_CHAR, 8'h00, 8'hff, LF_CHAR, "o", CR_CHAR});
	endtask

	// delete removes the last byte and is echoed
	task automatic test_delete();
		send_chars({"a", "b", DEL_CHAR, "z", CR_CHAR});
	endtask

	// lf stored alone, echoed without cr, and a silent delete with echo off
	task automatic test_crlf_options();
		write_settings(1'b1, 1'b0, 1'b0, LIMIT_RST);
		send_chars({"a", LF_CHAR});
		write_settings(1'b0, 1'b1, 1'b1, LIMIT_RST);
		send_chars({"c", DEL_CHAR, LF_CHAR});
	endtask

	// lf with no room for cr, limit below the minimum and above the depth
	task automatic test_limit_edges();
		write_settings(1'b1, 1'b1, 1'b1, 6'd4);
		send_chars({"a", "b", "c", LF_CHAR});
		write_settings(1'b1, 1'b1, 1'b1, 6'd0);
		send_chars({"x", "y"});
		write_settings(1'b0, 1'b0, 1'b1, 6'd63);
		send_chars({"q", CR_CHAR});
	endtask

	// limit dropped under the current length, then a byte or a delete
	task automatic test_limit_lowered();
		write_settings(1'b1, 1'b1, 1'b1, LIMIT_RST);
		send_chars({"a", "b", "c"});
		write_settings(1'b1, 1'b1, 1'b1, 6'd2);
		send_chars({"d"});
		write_settings(1'b1, 1'b1, 1'b1, LIMIT_RST);
		send_chars({"e", "f", "g"});
		write_settings(1'b1, 1'b1, 1'b1, 6'd2);
		send_chars({DEL_CHAR});
	endtask

	// typed lines with random edits and endings, some raw noise, across settings
	task automatic test_random_lines(input int n_items);
		logic [CHAR_W-1:0] seq[$];
		logic [LEN_W-1:0]  lim;
		int                phase;
		int                stop_at;
		int                phase_end;
		int                n_line;
		int                pick;
		phase   = 0;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			case (phase)
				0: write_settings(1'b1, 1'b1, 1'b1, LIMIT_RST);
				1: write_settings(1'b0, 1'b0, 1'b0, LIMIT_MIN);
				2: write_settings(1'b1, 1'b0, 1'b1, 6'd0);
				3: write_settings(1'b0, 1'b1, 1'b0, 6'd63);
				4: write_settings(1'b1, 1'b1, 1'b0, 6'd1);
				default: begin
					lim = ($urandom_range(0, 1) == 0) ? LEN_W'($urandom_range(0, 8)) :
						LEN_W'($urandom_range(0, 63));
					write_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), lim);
				end
			endcase
			phase_end = items_sent + $urandom_range(25, 45);
			while (items_sent < phase_end && items_sent < stop_at) begin
				seq.delete();
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					// raw bytes of any value
					repeat ($urandom_range(1, 6))
						seq.push_back(CHAR_W'($urandom_range(0, 255)));
				end else begin
					// a typed line, now and then a long one
					n_line = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 66) :
						$urandom_range(0, 10);
					repeat (n_line)
						seq.push_back(($urandom_range(0, 99) < 8) ? DEL_CHAR :
							CHAR_W'($urandom_range(8'h20, 8'h7e)));
					pick = $urandom_range(0, 99);
					if (pick < 45)
						seq.push_back(LF_CHAR);
					else if (pick < 80)
						seq.push_back(CR_CHAR);
				end
				send_chars(seq);
				// sender waits for the output to drain now and then
				if ($urandom_range(0, 19) == 0)
					settle();
			end
			phase++;
		end
	endtask

	// back to back requests with the output always ready
	task automatic test_streaming();
		no_gaps = 1'b1;
		test_random_lines(STREAM_ITEMS);
		settle();
		no_gaps = 1'b0;
	endtask

	// output back-pressure: short stalls mostly, a few long ones
	always @(posedge clk) begin
		if (no_gaps) begin
			out_ready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin : pick_stall
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				out_ready  <= 1'b1;
				ready_hold <= $urandom_range(0, 15);
			end else if (pick < 92) begin
				out_ready  <= 1'b0;
				ready_hold <= $urandom_range(0, 3);
			end else begin
				out_ready  <= 1'b0;
				ready_hold <= $urandom_range(15, 40);
			end
		end
	end

	// compare each result with the oldest expected byte
	always @(posedge clk) begin : check_results
		tty_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_exp.size() == 0) begin
				errors++;
				$display("%0t unexpected result kind=%0d char=%02h last=%0d",
					$time, kind, out_char, last);
			end else begin
				want = line_exp.pop_front();
				if (kind !== want.kind) begin
					errors++;
					$display("%0t kind mismatch: expected %0d actual %0d",
						$time, want.kind, kind);
				end
				if (out_char !== want.ch) begin
					errors++;
					$display("%0t out_char mismatch: expected %02h actual %02h",
						$time, want.ch, out_char);
				end
				if (last !== want.last) begin
					errors++;
					$display("%0t last mismatch: expected %0d actual %0d",
						$time, want.last, last);
				end
			end
		end
	end

	// watchdog on cycles with no request moved on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// reset, tests in turn, verdict
	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_ECHO_ENABLE;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		rx_char   <= '0;
		out_ready <= 1'b0;
		echo_on   = 1'b1;
		crlf_in   = 1'b1;
		crlf_out  = 1'b1;
		limit_reg = LIMIT_RST;
		line_len  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_line();
		test_delete();
		test_crlf_options();
		test_limit_edges();
		test_limit_lowered();
		test_streaming();
		test_random_lines(RANDOM_ITEMS);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/tld_pkg.sv
sv/tld_ctrl.sv
sv/tld_dp.sv
sv/tty_line_discipline_core.sv
tb/tty_line_discipline_core_tb.sv
